// ===== src/page_frame_run_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Page frame run allocator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define PFRA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define PFRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pfra_pkg.sv =====
// ----------------------------------------------------------------------------
// pfra_pkg
// Types and constants shared by the page frame run allocator modules.
// ----------------------------------------------------------------------------
package pfra_pkg;

	localparam int PAGE_W      = 16;
	localparam int CNT_W       = 17;
	localparam int LFC_W       = 7;
	localparam int LOCAL_LIMIT = 64;

	localparam logic [CNT_W-1:0] NIL     = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] KIND_INGEST = 2'd0;
	localparam logic [1:0] KIND_ALLOC  = 2'd1;
	localparam logic [1:0] KIND_FREE   = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOPAGE = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	localparam logic [1:0] REG_CACHE_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DAEMON_ATTACH  = 2'd1;
	localparam logic [1:0] REG_WAKE_FREE      = 2'd2;
	localparam logic [1:0] REG_WAKE_PERCENT   = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  page_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] alloc_page;
		logic              wake_daemon;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ING_A,
		CMD_ING_B,
		CMD_GRD,
		CMD_GPOP,
		CMD_LPUSH,
		CMD_LRD,
		CMD_LPOP,
		CMD_NOPAGE,
		CMD_REJECT,
		CMD_FREE_L,
		CMD_FREE_G
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       ing_ok;
		logic       page_zero;
		logic       g_empty;
		logic       l_empty;
		logic       l_room;
		logic       cache_en;
	} dp_status_t;

endpackage

// ===== src/page_frame_run_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_run_allocator
// Page frame allocator with a global free list of runs and a local page cache.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start while busy is low; the item transfers at
// that edge and busy rises. One result per item appears on result with done
// high for exactly one cycle; the receiver cannot stall it, and start may be
// raised again once busy falls. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// An alloc that finds the cache empty refills it from the global list, up to
// 64 pages, and then takes a page from it. The next item can transfer only
// after done, so items do not overlap. The link and run-length memories each
// have a single read port and a single write port, so each operation is
// walked through as a sequence of steps.
// Reset empties both lists and clears the counters; the memories themselves
// are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module page_frame_run_allocator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pfra_pkg::in_item_t   item,
	output logic                 busy,
	output logic                 done,
	output pfra_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [pfra_pkg::CNT_W-1:0] cfg_data
);

	pfra_pkg::cmd_t       cmd;
	pfra_pkg::dp_status_t st;

	pfra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pfra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.st        (st),
		.result    (result)
	);

endmodule

// ===== src/pfra_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfra_ctrl
// Sequencer that walks each operation through its datapath steps.
// ----------------------------------------------------------------------------
module pfra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pfra_pkg::dp_status_t st,
	output pfra_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_DECODE = 17'h00002,
		S_ING_A  = 17'h00004,
		S_ING_B  = 17'h00008,
		S_GRD    = 17'h00010,
		S_GPOP   = 17'h00020,
		S_RCHK   = 17'h00040,
		S_RGRD   = 17'h00080,
		S_RGPOP  = 17'h00100,
		S_RPUSH  = 17'h00200,
		S_LRD    = 17'h00400,
		S_LPOP   = 17'h00800,
		S_NOPAGE = 17'h01000,
		S_REJECT = 17'h02000,
		S_FREE_L = 17'h04000,
		S_FREE_G = 17'h08000,
		S_DONE   = 17'h10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (st.kind)
					pfra_pkg::KIND_INGEST: state_d = st.ing_ok ? S_ING_A : S_DONE;
					pfra_pkg::KIND_ALLOC: begin
						if (st.cache_en) state_d = st.l_empty ? S_RCHK : S_LRD;
						else state_d = st.g_empty ? S_NOPAGE : S_GRD;
					end
					pfra_pkg::KIND_FREE: begin
						if (st.page_zero) state_d = S_REJECT;
						else if (st.cache_en && st.l_room) state_d = S_FREE_L;
						else state_d = S_FREE_G;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ING_A:  state_d = S_ING_B;
			S_ING_B:  state_d = S_DONE;
			S_GRD:    state_d = S_GPOP;
			S_GPOP:   state_d = S_DONE;
			// The refill loop stops when the cache is full or the global list runs dry.
			S_RCHK: begin
				if (st.l_room && !st.g_empty) state_d = S_RGRD;
				else state_d = st.l_empty ? S_NOPAGE : S_LRD;
			end
			S_RGRD:   state_d = S_RGPOP;
			S_RGPOP:  state_d = S_RPUSH;
			S_RPUSH:  state_d = S_RCHK;
			S_LRD:    state_d = S_LPOP;
			S_LPOP:   state_d = S_DONE;
			S_NOPAGE: state_d = S_DONE;
			S_REJECT: state_d = S_DONE;
			S_FREE_L: state_d = S_DONE;
			S_FREE_G: state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd = start ? pfra_pkg::CMD_LOAD : pfra_pkg::CMD_NONE;
			S_ING_A:  cmd = pfra_pkg::CMD_ING_A;
			S_ING_B:  cmd = pfra_pkg::CMD_ING_B;
			S_GRD:    cmd = pfra_pkg::CMD_GRD;
			S_RGRD:   cmd = pfra_pkg::CMD_GRD;
			S_GPOP:   cmd = pfra_pkg::CMD_GPOP;
			S_RGPOP:  cmd = pfra_pkg::CMD_GPOP;
			S_RPUSH:  cmd = pfra_pkg::CMD_LPUSH;
			S_LRD:    cmd = pfra_pkg::CMD_LRD;
			S_LPOP:   cmd = pfra_pkg::CMD_LPOP;
			S_NOPAGE: cmd = pfra_pkg::CMD_NOPAGE;
			S_REJECT: cmd = pfra_pkg::CMD_REJECT;
			S_FREE_L: cmd = pfra_pkg::CMD_FREE_L;
			S_FREE_G: cmd = pfra_pkg::CMD_FREE_G;
			default:  cmd = pfra_pkg::CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== src/pfra_dp.sv =====
// ----------------------------------------------------------------------------
// pfra_dp
// Link and run-length memories, list pointers, counters and result registers.
// ----------------------------------------------------------------------------
module pfra_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfra_pkg::cmd_t       cmd,
	input  pfra_pkg::in_item_t   item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [pfra_pkg::CNT_W-1:0] cfg_data,
	output pfra_pkg::dp_status_t st,
	output pfra_pkg::out_item_t  result
);

	localparam int PW = pfra_pkg::PAGE_W;
	localparam int CW = pfra_pkg::CNT_W;
	localparam int LW = pfra_pkg::LFC_W;

	logic [CW-1:0] rl_mem [2**PW];
	logic [CW-1:0] nl_mem [2**PW];
	logic [CW-1:0] rd_rl_q, rd_nl_q;

	logic [1:0]    kind_q;
	logic [PW-1:0] page_q, pop_q, got_q;
	logic [CW-1:0] cnt_q, head_q, tail_q, lhead_q, gfc_q;
	logic [LW-1:0] lfc_q;
	logic [1:0]    status_q;
	logic          wake_q;
	logic          cache_en_q, daemon_q;
	logic [CW-1:0] wake_free_q, wake_pct_q;

	logic [CW-1:0] room, cnt_clip, gfc_ing, gfc_inc, gfc_dec, pop_next;
	logic [CW:0]   sum_ing, sum_inc;
	logic          split;
	logic [PW-1:0] pop_p1;

	logic          rl_we, nl_we;
	logic [PW-1:0] rl_wa, nl_wa, rd_addr;
	logic [CW-1:0] rl_wd, nl_wd;

	assign room     = CW'(2**PW) - CW'(page_q);
	assign cnt_clip = (cnt_q > room) ? room : cnt_q;
	assign sum_ing  = {1'b0, gfc_q} + {1'b0, cnt_clip};
	assign gfc_ing  = sum_ing[CW] ? pfra_pkg::CNT_MAX : sum_ing[CW-1:0];
	assign sum_inc  = {1'b0, gfc_q} + (CW+1)'(1);
	assign gfc_inc  = sum_inc[CW] ? pfra_pkg::CNT_MAX : sum_inc[CW-1:0];
	assign gfc_dec  = (gfc_q != '0) ? gfc_q - CW'(1) : gfc_q;
	assign pop_next = rd_nl_q;
	// The rest of a split run goes back to the front, starting one page later.
	assign split    = (rd_rl_q > CW'(1)) && (pop_q != '1);
	assign pop_p1   = pop_q + PW'(1);

	always_comb begin
		rl_we   = 1'b0;
		nl_we   = 1'b0;
		rl_wa   = page_q;
		nl_wa   = page_q;
		rl_wd   = CW'(1);
		nl_wd   = head_q;
		rd_addr = head_q[PW-1:0];
		case (cmd)
			pfra_pkg::CMD_ING_A: begin
				rl_we = 1'b1;
				rl_wd = cnt_clip;
				nl_we = 1'b1;
				nl_wd = pfra_pkg::NIL;
			end
			pfra_pkg::CMD_ING_B: begin
				nl_we = !tail_q[CW-1];
				nl_wa = tail_q[PW-1:0];
				nl_wd = CW'(page_q);
			end
			pfra_pkg::CMD_GPOP: begin
				rl_we = split;
				rl_wa = pop_p1;
				rl_wd = rd_rl_q - CW'(1);
				nl_we = split;
				nl_wa = pop_p1;
				nl_wd = pop_next;
			end
			pfra_pkg::CMD_LPUSH: begin
				rl_we = 1'b1;
				rl_wa = pop_q;
				nl_we = 1'b1;
				nl_wa = pop_q;
				nl_wd = lhead_q;
			end
			pfra_pkg::CMD_LRD: rd_addr = lhead_q[PW-1:0];
			pfra_pkg::CMD_FREE_L: begin
				rl_we = 1'b1;
				nl_we = 1'b1;
				nl_wd = lhead_q;
			end
			pfra_pkg::CMD_FREE_G: begin
				rl_we = 1'b1;
				nl_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rl_we) rl_mem[rl_wa] <= rl_wd;
		rd_rl_q <= rl_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (nl_we) nl_mem[nl_wa] <= nl_wd;
		rd_nl_q <= nl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= pfra_pkg::NIL;
			tail_q     <= pfra_pkg::NIL;
			lhead_q    <= pfra_pkg::NIL;
			gfc_q      <= '0;
			lfc_q      <= '0;
			cache_en_q <= 1'b0;
			daemon_q   <= 1'b0;
			wake_free_q <= CW'(512);
			wake_pct_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfra_pkg::REG_CACHE_ENABLE:  cache_en_q  <= cfg_data[0];
					pfra_pkg::REG_DAEMON_ATTACH: daemon_q    <= cfg_data[0];
					pfra_pkg::REG_WAKE_FREE:     wake_free_q <= cfg_data;
					pfra_pkg::REG_WAKE_PERCENT:  wake_pct_q  <= cfg_data;
					default: ;
				endcase
			end
			case (cmd)
				pfra_pkg::CMD_ING_A: gfc_q <= gfc_ing;
				pfra_pkg::CMD_ING_B: begin
					if (tail_q[CW-1]) head_q <= CW'(page_q);
					tail_q <= CW'(page_q);
				end
				pfra_pkg::CMD_GPOP: begin
					gfc_q <= gfc_dec;
					if (split) begin
						head_q <= CW'(pop_p1);
						if (pop_next[CW-1]) tail_q <= CW'(pop_p1);
					end else begin
						head_q <= pop_next;
						if (pop_next[CW-1]) tail_q <= pfra_pkg::NIL;
					end
				end
				pfra_pkg::CMD_LPUSH: begin
					lhead_q <= CW'(pop_q);
					lfc_q   <= lfc_q + LW'(1);
				end
				pfra_pkg::CMD_LPOP: begin
					lhead_q <= rd_nl_q;
					if (lfc_q != '0) lfc_q <= lfc_q - LW'(1);
				end
				pfra_pkg::CMD_FREE_L: begin
					lhead_q <= CW'(page_q);
					lfc_q   <= lfc_q + LW'(1);
				end
				pfra_pkg::CMD_FREE_G: begin
					if (head_q[CW-1]) tail_q <= CW'(page_q);
					head_q <= CW'(page_q);
					gfc_q  <= gfc_inc;
				end
				default: ;
			endcase
		end
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		case (cmd)
			pfra_pkg::CMD_LOAD: begin
				kind_q   <= item.kind;
				page_q   <= item.page;
				cnt_q    <= item.page_count;
				status_q <= pfra_pkg::STATUS_OK;
				got_q    <= '0;
				wake_q   <= 1'b0;
			end
			pfra_pkg::CMD_GRD: pop_q <= head_q[PW-1:0];
			pfra_pkg::CMD_LRD: pop_q <= lhead_q[PW-1:0];
			pfra_pkg::CMD_GPOP: begin
				got_q <= pop_q;
				if (daemon_q && (gfc_dec < wake_free_q || gfc_dec < wake_pct_q))
					wake_q <= 1'b1;
			end
			pfra_pkg::CMD_LPOP: got_q <= pop_q;
			pfra_pkg::CMD_NOPAGE: begin
				status_q <= pfra_pkg::STATUS_NOPAGE;
				got_q    <= '0;
			end
			pfra_pkg::CMD_REJECT: status_q <= pfra_pkg::STATUS_REJECT;
			default: ;
		endcase
	end

	assign st.kind      = kind_q;
	assign st.ing_ok    = (cnt_q != '0);
	assign st.page_zero = (page_q == '0);
	assign st.g_empty   = head_q[CW-1];
	assign st.l_empty   = lhead_q[CW-1];
	assign st.l_room    = (lfc_q < LW'(pfra_pkg::LOCAL_LIMIT));
	assign st.cache_en  = cache_en_q;

	assign result.status      = status_q;
	assign result.alloc_page  = got_q;
	assign result.wake_daemon = wake_q;

endmodule

// ===== src/pfra_checker.sv =====
// ----------------------------------------------------------------------------
// pfra_checker
// Port-level checks of the allocator command and result behavior.
// ----------------------------------------------------------------------------
`include "page_frame_run_allocator_macros.svh"

module pfra_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input pfra_pkg::out_item_t result
);

	`PFRA_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`PFRA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
	`PFRA_ASSERT_NOW(a_done_busy, done, busy, "result shown while idle")
	`PFRA_ASSERT_NOW(a_fail_nopage, done && result.status != pfra_pkg::STATUS_OK, result.alloc_page == '0, "failed item returned a page")

endmodule

bind page_frame_run_allocator pfra_checker u_pfra_checker (.*);
